@@ rtl/fha_pkg.sv @@
`default_nettype none

package fha_pkg;

    // One input item as it arrives on the request channel.
    typedef struct packed {
        logic [1:0]  req_type;
        logic [3:0]  cell_row;
        logic [6:0]  cell_col;
        logic        hot_bit;
        logic [31:0] time_ms;
    } in_item_t;

    // One result item as it leaves on the result channel.
    typedef struct packed {
        logic        stepped;
        logic        visible;
        logic [3:0]  ramp_index;
        logic [15:0] cell_color;
        logic [7:0]  cell_heat;
    } out_item_t;

    // Request codes on the wire.
    localparam logic [1:0] REQ_CODE_LOAD = 2'd0;
    localparam logic [1:0] REQ_CODE_TICK = 2'd1;
    localparam logic [1:0] REQ_CODE_READ = 2'd2;

    // Class that the front end attaches to every queued item.
    typedef enum logic [1:0] {
        CLS_LOAD,
        CLS_TICK,
        CLS_READ,
        CLS_NONE
    } req_class_t;

    typedef struct packed {
        req_class_t cls;
        in_item_t   item;
    } q_entry_t;

    // Configuration registers.
    typedef struct packed {
        logic [4:0] rows;
        logic [6:0] cols;
        logic [9:0] period;
    } cfg_t;

    localparam logic [1:0] CFG_ROWS   = 2'd0;
    localparam logic [1:0] CFG_COLS   = 2'd1;
    localparam logic [1:0] CFG_PERIOD = 2'd2;

    localparam logic [4:0] RESET_ROWS   = 5'd16;
    localparam logic [6:0] RESET_COLS   = 7'd80;
    localparam logic [9:0] RESET_PERIOD = 10'd45;

    localparam logic [7:0] HOT_HEAT    = 8'd255;
    localparam logic [7:0] WARM_HEAT   = 8'd90;
    localparam logic [7:0] COOLING     = 8'd14;
    localparam logic [7:0] VISIBLE_MIN = 8'd24;
    localparam logic [7:0] BLUE_KNEE   = 8'd180;

    // Back end sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SRC,
        ST_ROW_RD,
        ST_ROW_DRAIN,
        ST_READ_WAIT
    } st_t;

    // Colour data of one cell that is in range.
    function automatic out_item_t read_result(input logic [7:0] v);
        logic [11:0] v9;
        logic [3:0]  idx;
        logic [19:0] gp;
        logic [7:0]  g;
        logic [9:0]  b;
        out_item_t   r;
        v9  = 12'(v) * 12'd9;
        idx = 4'd0;
        // Ramp level counts the thresholds of 255 that 9*v reaches.
        for (int k = 1; k <= 9; k++)
        begin
            if (v9 >= 12'(k * 255))
            begin
                idx = idx + 4'd1;
            end
        end
        // Division of 4*v by five through its reciprocal 205/1024.
        gp = 20'({v, 2'b00}) * 20'd205;
        g  = gp[17:10];
        b  = (v > BLUE_KNEE) ? 10'(v - BLUE_KNEE) * 10'd3 : 10'd0;
        r.stepped    = 1'b0;
        r.visible    = (v >= VISIBLE_MIN);
        r.ramp_index = idx;
        r.cell_color = {5'b11111, g[7:2], b[7:3]};
        r.cell_heat  = v;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/fha_ram.sv @@
`default_nettype none

module fha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1360
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/fha_front.sv @@
`default_nettype none

module fha_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire fha_pkg::in_item_t in_data,
    input  wire logic              hold,
    output logic                   q_valid,
    output fha_pkg::q_entry_t      q_data,
    input  wire logic              q_pop
);

    import fha_pkg::*;

    q_entry_t   ent_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;
    req_class_t cls;

    // Refuse items while the queue is full or the grid is being cleared.
    assign in_stall = (cnt_reg == 2'd2) || hold;
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_data   = ent_reg[rd_ptr_reg];

    // Classify the request type once, on entry.
    always_comb
    begin
        case (in_data.req_type)
            REQ_CODE_LOAD: cls = CLS_LOAD;
            REQ_CODE_TICK: cls = CLS_TICK;
            REQ_CODE_READ: cls = CLS_READ;
            default:       cls = CLS_NONE;
        endcase
    end

    // Queue payload.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= '{cls: cls, item: in_data};
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop);
        end
    end

endmodule

`default_nettype wire

@@ rtl/fha_back.sv @@
`default_nettype none

module fha_back #(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 80
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire fha_pkg::cfg_t     cfg,
    input  wire logic              q_valid,
    input  wire fha_pkg::q_entry_t q_data,
    output logic                   q_pop,
    output logic                   clearing,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output fha_pkg::out_item_t     out_data
);

    import fha_pkg::*;

    localparam int DEPTH = (MAX_ROWS + 1) * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int RCW   = $clog2(MAX_ROWS + 1);
    localparam int JW    = $clog2(MAX_COLS + 2);

    st_t                 state_reg, state_next;
    logic [AW-1:0]       clr_reg, clr_next;
    logic [JW-1:0]       col_reg, col_next;
    logic [RCW-1:0]      row_reg, row_next;
    logic [7:0]          w1_reg, w1_next;
    logic [7:0]          w2_reg, w2_next;
    logic                rd_pend_reg, rd_pend_next;
    logic [JW-1:0]       rd_j_reg, rd_j_next;
    logic [31:0]         last_reg, last_next;
    logic [31:0]         now_reg, now_next;
    logic [MAX_COLS-1:0] pend_reg, pend_next;
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_data_reg, out_data_next;

    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [7:0]     ram_wdata;
    logic           ram_re;
    logic [AW-1:0]  ram_raddr;
    logic [7:0]     ram_rdata;

    logic [RCW-1:0] nr;
    logic [JW-1:0]  nc;
    in_item_t       it;
    logic           dispatch;
    logic           in_range;
    logic           step_due;
    logic           src_last;
    logic           j_last;
    logic [JW-1:0]  rd_col;
    logic [9:0]     win_sum;
    logic [7:0]     win_q;
    logic [7:0]     cooled;
    out_item_t      stepped_item;

    function automatic logic [AW-1:0] cell_addr(input int unsigned r, input int unsigned c);
        return AW'(r * MAX_COLS + c);
    endfunction

    // Rows and columns in use, limited by the grid size.
    assign nr = (32'(cfg.rows) < MAX_ROWS) ? RCW'(cfg.rows) : RCW'(MAX_ROWS);
    assign nc = (32'(cfg.cols) < MAX_COLS) ? JW'(cfg.cols) : JW'(MAX_COLS);

    // Dispatch from the queue when the sequencer is idle and the result register is free.
    assign it       = q_data.item;
    assign dispatch = (state_reg == ST_IDLE) && q_valid && (!out_valid_reg || !out_stall);
    assign q_pop    = dispatch;
    assign clearing = (state_reg == ST_CLEAR);
    assign in_range = (32'(it.cell_row) < 32'(nr)) && (32'(it.cell_col) < 32'(nc));
    assign step_due = (last_reg == 32'd0) || ((it.time_ms - last_reg) >= 32'(cfg.period));

    // Column sequencing of the source row and of one row update.
    assign src_last = (col_reg == nc - JW'(1));
    assign j_last   = (col_reg == nc + JW'(1));
    always_comb
    begin
        if (col_reg == '0)
        begin
            rd_col = nc - JW'(1);
        end
        else if (j_last)
        begin
            rd_col = '0;
        end
        else
        begin
            rd_col = col_reg - JW'(1);
        end
    end

    // Weighted average of the window over the row below, then cooling.
    assign win_sum = 10'(w1_reg) + {1'b0, w2_reg, 1'b0} + 10'(ram_rdata);
    assign win_q   = win_sum[9:2];
    assign cooled  = (win_q > COOLING) ? win_q - COOLING : 8'd0;

    always_comb
    begin
        stepped_item         = '0;
        stepped_item.stepped = 1'b1;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (dispatch && q_data.cls == CLS_TICK && step_due && nc != '0)
                begin
                    state_next = ST_SRC;
                end
                else if (dispatch && q_data.cls == CLS_READ && in_range)
                begin
                    state_next = ST_READ_WAIT;
                end
            end
            ST_SRC:
            begin
                if (src_last)
                begin
                    state_next = (nr == '0) ? ST_IDLE : ST_ROW_RD;
                end
            end
            ST_ROW_RD:
            begin
                if (j_last)
                begin
                    state_next = ST_ROW_DRAIN;
                end
            end
            ST_ROW_DRAIN:
            begin
                state_next = (row_reg == '0) ? ST_IDLE : ST_ROW_RD;
            end
            ST_READ_WAIT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, memory controls and result register.
    always_comb
    begin
        clr_next       = clr_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        w1_next        = w1_reg;
        w2_next        = w2_reg;
        rd_pend_next   = 1'b0;
        rd_j_next      = rd_j_reg;
        last_next      = last_reg;
        now_next       = now_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + AW'(1);
            end
            ST_IDLE:
            begin
                if (dispatch)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    case (q_data.cls)
                        CLS_LOAD:
                        begin
                            if (32'(it.cell_col) < MAX_COLS)
                            begin
                                pend_next[CW'(it.cell_col)] = it.hot_bit;
                            end
                        end
                        CLS_TICK:
                        begin
                            if (step_due)
                            begin
                                now_next = it.time_ms;
                                col_next = '0;
                                if (nc == '0)
                                begin
                                    last_next     = (it.time_ms == 32'd0) ? 32'd1 : it.time_ms;
                                    out_data_next = stepped_item;
                                end
                                else
                                begin
                                    out_valid_next = 1'b0;
                                end
                            end
                        end
                        CLS_READ:
                        begin
                            if (in_range)
                            begin
                                ram_re         = 1'b1;
                                ram_raddr      = cell_addr(32'(it.cell_row), 32'(it.cell_col));
                                out_valid_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            out_data_next = '0;
                        end
                    endcase
                end
            end
            ST_SRC:
            begin
                ram_we    = 1'b1;
                ram_waddr = cell_addr(32'(nr), 32'(col_reg));
                ram_wdata = pend_reg[col_reg[CW-1:0]] ? HOT_HEAT : WARM_HEAT;
                col_next  = col_reg + JW'(1);
                if (src_last)
                begin
                    col_next = '0;
                    if (nr == '0)
                    begin
                        last_next      = (now_reg == 32'd0) ? 32'd1 : now_reg;
                        out_valid_next = 1'b1;
                        out_data_next  = stepped_item;
                    end
                    else
                    begin
                        row_next = nr - RCW'(1);
                    end
                end
            end
            ST_ROW_RD:
            begin
                ram_re       = 1'b1;
                ram_raddr    = cell_addr(32'(row_reg) + 32'd1, 32'(rd_col));
                rd_pend_next = 1'b1;
                rd_j_next    = col_reg;
                col_next     = col_reg + JW'(1);
            end
            ST_ROW_DRAIN:
            begin
                col_next = '0;
                if (row_reg == '0)
                begin
                    last_next      = (now_reg == 32'd0) ? 32'd1 : now_reg;
                    out_valid_next = 1'b1;
                    out_data_next  = stepped_item;
                end
                else
                begin
                    row_next = row_reg - RCW'(1);
                end
            end
            ST_READ_WAIT:
            begin
                out_valid_next = 1'b1;
                out_data_next  = read_result(ram_rdata);
            end
            default:
            begin
                col_next = '0;
            end
        endcase

        // Returning read data of a row update slides the window and, once it holds three cells, writes a cell.
        if (rd_pend_reg)
        begin
            w1_next = w2_reg;
            w2_next = ram_rdata;
            if (rd_j_reg >= JW'(2))
            begin
                ram_we    = 1'b1;
                ram_waddr = cell_addr(32'(row_reg), 32'(rd_j_reg - JW'(2)));
                ram_wdata = cooled;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            rd_j_reg      <= '0;
            last_reg      <= 32'd0;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            rd_pend_reg   <= rd_pend_next;
            rd_j_reg      <= rd_j_next;
            last_reg      <= last_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        w1_reg       <= w1_next;
        w2_reg       <= w2_next;
        now_reg      <= now_next;
        out_data_reg <= out_data_next;
    end

    fha_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_heat_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // No item leaves the queue while the grid is being cleared.
    a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !q_pop)
        else $error("queue popped during clearing pass");

    // Every write lands inside the heat store.
    a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (32'(ram_waddr) < DEPTH))
        else $error("heat store write out of range");

    // The drain cycle always receives the last read of the row.
    a_drain_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROW_DRAIN) |-> rd_pend_reg)
        else $error("row drain without pending read");

    // A cell read always leaves a valid result in the result register after its read wait state.
    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ_WAIT) |=> out_valid_reg)
        else $error("cell read gave no result");

endmodule

`default_nettype wire

@@ rtl/fire_heat_automaton_unit.sv @@
`default_nettype none

// Fire heat automaton: keeps an 8-bit heat grid with a source row under the
// visible rows, and answers load, tick and read requests with one result each.
// Requests enter a two-entry queue and are carried out in order by a sequencer
// around one heat memory with one write and one registered read port. A load,
// a tick that does not step, an out-of-range read or an unused request is
// answered from the idle state; an in-range read passes a read wait state for
// the registered memory read. In a tick that steps with C columns and R rows
// in use, the source row is written one column a cycle, then every row streams
// C+2 reads of the row below and passes a drain state. After reset the heat
// memory is cleared one cell a cycle, all (MAX_ROWS+1)*MAX_COLS cells (1360 by
// default), during which requests are stalled; configuration writes are
// taken at any time and must only be made while the block is idle.
module fire_heat_automaton_unit #(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 80
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire fha_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output fha_pkg::out_item_t      out_data,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [9:0]         cfg_data
);

    import fha_pkg::*;

    cfg_t     cfg_reg;
    logic     q_valid;
    q_entry_t q_data;
    logic     q_pop;
    logic     clearing;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rows   <= RESET_ROWS;
            cfg_reg.cols   <= RESET_COLS;
            cfg_reg.period <= RESET_PERIOD;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ROWS:   cfg_reg.rows   <= cfg_data[4:0];
                CFG_COLS:   cfg_reg.cols   <= cfg_data[6:0];
                CFG_PERIOD: cfg_reg.period <= cfg_data;
                default:    cfg_reg.rows   <= cfg_reg.rows;
            endcase
        end
    end

    fha_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .hold     (clearing),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop)
    );

    fha_back #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .clearing  (clearing),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
